@@ rtl/vmt_pkg.sv @@
// Package for the step-limited 2-D move: widths, pipeline depths, sideband types.
// No dependencies; used by vmt_sqrt, vmt_div and vector2_move_towards.
`timescale 1ns / 1ps
package vmt_pkg;

   localparam int XW        = 32;          // coordinate width
   localparam int DW        = 33;          // difference width
   localparam int PW        = 64;          // product width
   localparam int SW        = 66;          // squared length width
   localparam int RW        = 33;          // root width
   localparam int RMW       = 35;          // root remainder width
   localparam int QW        = 35;          // quotient width
   localparam int DRW       = 34;          // divider remainder width
   localparam int OW        = 35;          // signed offset and sum width
   localparam int SQ_STAGES = SW / 2;
   localparam int DV_STAGES = QW;

   localparam logic [QW-1:0] OFFSET_CAP = QW'(64'h2_0000_0000);

   // sideband carried alongside the root pipeline
   typedef struct packed {
      logic [XW-1:0] cur_x;
      logic [XW-1:0] cur_y;
      logic [XW-1:0] tgt_x;
      logic [XW-1:0] tgt_y;
      logic          neg_x;
      logic          neg_y;
      logic          reach;
      logic [PW-1:0] mag_x;
      logic [PW-1:0] mag_y;
   } root_side_type;

   // sideband carried alongside the divider pipeline
   typedef struct packed {
      logic [XW-1:0] cur_x;
      logic [XW-1:0] cur_y;
      logic [XW-1:0] tgt_x;
      logic [XW-1:0] tgt_y;
      logic          neg_x;
      logic          neg_y;
      logic          reach;
      logic          zero_len;
      logic          ovf_x;
      logic          ovf_y;
   } div_side_type;

   // clamp a signed sum to the 32-bit range
   function automatic logic [XW-1:0] sat32(input logic [OW-1:0] v);
      logic [OW-1:0] hi_lim;
      logic [OW-1:0] lo_lim;
      logic [XW-1:0] res;
      hi_lim = OW'({1'b0, {(XW-1){1'b1}}});
      lo_lim = {{(OW-XW+1){1'b1}}, {(XW-1){1'b0}}};
      if (!v[OW-1] && (v > hi_lim)) begin
         res = hi_lim[XW-1:0];
      end else if (v[OW-1] && (v < lo_lim)) begin
         res = lo_lim[XW-1:0];
      end else begin
         res = v[XW-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/vmt_sqrt.sv @@
// Pipelined integer square root, two radicand bits per stage.
// Depends on vmt_pkg.
`timescale 1ns / 1ps
module vmt_sqrt import vmt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [SW-1:0] in_s,
   output logic          out_valid,
   output logic [RW-1:0] out_root
);

   logic          v_ff    [SQ_STAGES];
   logic [SW-1:0] s_ff    [SQ_STAGES];
   logic [RMW-1:0] rem_ff [SQ_STAGES];
   logic [RW-1:0] root_ff [SQ_STAGES];

   genvar k;
   generate
      for (k = 0; k < SQ_STAGES; k++) begin : g_stage
         logic          v_src;
         logic [SW-1:0] s_src;
         logic [RMW-1:0] rem_src;
         logic [RW-1:0] root_src;
         logic [RMW+1:0] trial;
         logic [RMW+1:0] tval;
         logic          ge;
         logic [RMW-1:0] rem_in;
         logic [RW-1:0] root_in;

         // pick the previous stage or the input word
         if (k == 0) begin : g_first
            assign v_src    = in_valid;
            assign s_src    = in_s;
            assign rem_src  = '0;
            assign root_src = '0;
         end else begin : g_next
            assign v_src    = v_ff[k-1];
            assign s_src    = s_ff[k-1];
            assign rem_src  = rem_ff[k-1];
            assign root_src = root_ff[k-1];
         end

         // try the next root bit against the remainder
         assign trial   = {rem_src, s_src[SW-1 -: 2]};
         assign tval    = {2'b00, root_src, 2'b01};
         assign ge      = (trial >= tval);
         assign rem_in  = ge ? RMW'(trial - tval) : RMW'(trial);
         assign root_in = {root_src[RW-2:0], ge};

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else begin
               v_ff[k] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            s_ff[k]    <= {s_src[SW-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   endgenerate

   assign out_valid = v_ff[SQ_STAGES-1];
   assign out_root  = root_ff[SQ_STAGES-1];

endmodule

@@ rtl/vmt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vmt_pkg; the caller guarantees the quotient fits QW bits.
`timescale 1ns / 1ps
module vmt_div import vmt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [PW-1:0] in_num,
   input  logic [RW-1:0] in_den,
   output logic          out_valid,
   output logic [QW-1:0] out_quo
);

   logic           v_ff   [DV_STAGES];
   logic [PW-1:0]  num_ff [DV_STAGES];
   logic [RW-1:0]  den_ff [DV_STAGES];
   logic [DRW-1:0] rem_ff [DV_STAGES];
   logic [QW-1:0]  quo_ff [DV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DV_STAGES; k++) begin : g_stage
         logic           v_src;
         logic [PW-1:0]  num_src;
         logic [RW-1:0]  den_src;
         logic [DRW-1:0] rem_src;
         logic [QW-1:0]  quo_src;
         logic [DRW:0]   trial;
         logic           ge;
         logic [DRW-1:0] rem_in;

         // start from the high numerator bits, or take the previous stage
         if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign num_src = in_num;
            assign den_src = in_den;
            assign rem_src = DRW'(in_num[PW-1:QW]);
            assign quo_src = '0;
         end else begin : g_next
            assign v_src   = v_ff[k-1];
            assign num_src = num_ff[k-1];
            assign den_src = den_ff[k-1];
            assign rem_src = rem_ff[k-1];
            assign quo_src = quo_ff[k-1];
         end

         // shift in one numerator bit and subtract if it fits
         assign trial  = {rem_src, num_src[QW-1-k]};
         assign ge     = (trial >= (DRW+1)'(den_src));
         assign rem_in = ge ? DRW'(trial - (DRW+1)'(den_src)) : DRW'(trial);

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else begin
               v_ff[k] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            num_ff[k] <= num_src;
            den_ff[k] <= den_src;
            rem_ff[k] <= rem_in;
            quo_ff[k] <= {quo_src[QW-2:0], ge};
         end
      end
   endgenerate

   assign out_valid = v_ff[DV_STAGES-1];
   assign out_quo   = quo_ff[DV_STAGES-1];

endmodule

@@ rtl/vector2_move_towards.sv @@
// Top level of the step-limited 2-D move: input decode, products, root,
// division and output rounding. Depends on vmt_pkg, vmt_sqrt and vmt_div.
//
// Usage:
//   Input channel: drive req_* and pulse start; a word is taken at each edge
//   with start high and busy low. busy is always low, so a word may be given
//   every cycle.
//   Result channel: rsp_valid is high for one cycle with rsp_new_x, rsp_new_y
//   and rsp_reached; the receiver must take it in that cycle.
//   Pipeline: the 33-stage root pipeline (two radicand bits a stage) and the
//   35-stage divider (one quotient bit a stage), plus five decode, product,
//   sum, rounding-bias and output register stages.
//   Throughput: one word per cycle; results leave in input order.
//   Reset: synchronous reset clears all valid bits, so words in flight are
//   dropped; no clearing pass is needed and the block takes words right after.
//   Stalls: the receiver cannot hold off results, so the pipeline never stops.
`timescale 1ns / 1ps
module vector2_move_towards import vmt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [XW-1:0] req_cur_x,
   input  logic signed [XW-1:0] req_cur_y,
   input  logic signed [XW-1:0] req_tgt_x,
   input  logic signed [XW-1:0] req_tgt_y,
   input  logic signed [XW-1:0] req_max_step,
   output logic                 rsp_valid,
   output logic signed [XW-1:0] rsp_new_x,
   output logic signed [XW-1:0] rsp_new_y,
   output logic                 rsp_reached
);

   // the pipeline never stops
   assign busy = 1'b0;

   // stage 1: differences and magnitudes
   logic          s1_v_ff;
   logic [XW-1:0] s1_cx_ff, s1_cy_ff, s1_tx_ff, s1_ty_ff;
   logic [XW-1:0] s1_ax_ff, s1_ay_ff, s1_as_ff;
   logic          s1_dxn_ff, s1_dyn_ff, s1_sn_ff;
   logic [DW-1:0] dx_in, dy_in, st_ext;

   assign dx_in  = {req_tgt_x[XW-1], req_tgt_x} - {req_cur_x[XW-1], req_cur_x};
   assign dy_in  = {req_tgt_y[XW-1], req_tgt_y} - {req_cur_y[XW-1], req_cur_y};
   assign st_ext = {req_max_step[XW-1], req_max_step};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      s1_cx_ff  <= req_cur_x;
      s1_cy_ff  <= req_cur_y;
      s1_tx_ff  <= req_tgt_x;
      s1_ty_ff  <= req_tgt_y;
      s1_dxn_ff <= dx_in[DW-1];
      s1_dyn_ff <= dy_in[DW-1];
      s1_sn_ff  <= req_max_step[XW-1];
      s1_ax_ff  <= dx_in[DW-1] ? XW'(-dx_in) : dx_in[XW-1:0];
      s1_ay_ff  <= dy_in[DW-1] ? XW'(-dy_in) : dy_in[XW-1:0];
      s1_as_ff  <= req_max_step[XW-1] ? XW'(-st_ext) : st_ext[XW-1:0];
   end

   // stage 2: products
   logic          s2_v_ff;
   logic [XW-1:0] s2_cx_ff, s2_cy_ff, s2_tx_ff, s2_ty_ff;
   logic [PW-1:0] s2_sx2_ff, s2_sy2_ff, s2_st2_ff, s2_mx_ff, s2_my_ff;
   logic          s2_nx_ff, s2_ny_ff, s2_sn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_cx_ff  <= s1_cx_ff;
      s2_cy_ff  <= s1_cy_ff;
      s2_tx_ff  <= s1_tx_ff;
      s2_ty_ff  <= s1_ty_ff;
      s2_nx_ff  <= s1_dxn_ff ^ s1_sn_ff;
      s2_ny_ff  <= s1_dyn_ff ^ s1_sn_ff;
      s2_sn_ff  <= s1_sn_ff;
      s2_sx2_ff <= PW'(s1_ax_ff) * PW'(s1_ax_ff);
      s2_sy2_ff <= PW'(s1_ay_ff) * PW'(s1_ay_ff);
      s2_st2_ff <= PW'(s1_as_ff) * PW'(s1_as_ff);
      s2_mx_ff  <= PW'(s1_ax_ff) * PW'(s1_as_ff);
      s2_my_ff  <= PW'(s1_ay_ff) * PW'(s1_as_ff);
   end

   // stage 3: squared length and reach test
   logic          s3_v_ff;
   logic [SW-1:0] s3_s_ff;
   root_side_type s3_side_ff;
   logic [PW:0]   sum_in;

   assign sum_in = {1'b0, s2_sx2_ff} + {1'b0, s2_sy2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_s_ff          <= SW'(sum_in);
      s3_side_ff.cur_x <= s2_cx_ff;
      s3_side_ff.cur_y <= s2_cy_ff;
      s3_side_ff.tgt_x <= s2_tx_ff;
      s3_side_ff.tgt_y <= s2_ty_ff;
      s3_side_ff.neg_x <= s2_nx_ff;
      s3_side_ff.neg_y <= s2_ny_ff;
      s3_side_ff.reach <= !s2_sn_ff && (sum_in <= {1'b0, s2_st2_ff});
      s3_side_ff.mag_x <= s2_mx_ff;
      s3_side_ff.mag_y <= s2_my_ff;
   end

   // root pipeline, sideband delayed to match
   logic          sq_v;
   logic [RW-1:0] sq_root;
   root_side_type rs_ff [SQ_STAGES];

   vmt_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_s      (s3_s_ff),
      .out_valid (sq_v),
      .out_root  (sq_root)
   );

   always_ff @(posedge clock) begin
      rs_ff[0] <= s3_side_ff;
      for (int i = 1; i < SQ_STAGES; i++) begin
         rs_ff[i] <= rs_ff[i-1];
      end
   end

   // rounding bias, overflow test and zero length
   logic          d0_v_ff;
   logic [PW-1:0] d0_nx_ff, d0_ny_ff;
   logic [RW-1:0] d0_len_ff;
   div_side_type  d0_side_ff;
   root_side_type rs_out;
   logic [PW-1:0] nx_in, ny_in;

   assign rs_out = rs_ff[SQ_STAGES-1];
   assign nx_in  = rs_out.mag_x + PW'(sq_root[RW-1:1]);
   assign ny_in  = rs_out.mag_y + PW'(sq_root[RW-1:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_v_ff <= 1'b0;
      end else begin
         d0_v_ff <= sq_v;
      end
   end

   always_ff @(posedge clock) begin
      d0_nx_ff            <= nx_in;
      d0_ny_ff            <= ny_in;
      d0_len_ff           <= sq_root;
      d0_side_ff.cur_x    <= rs_out.cur_x;
      d0_side_ff.cur_y    <= rs_out.cur_y;
      d0_side_ff.tgt_x    <= rs_out.tgt_x;
      d0_side_ff.tgt_y    <= rs_out.tgt_y;
      d0_side_ff.neg_x    <= rs_out.neg_x;
      d0_side_ff.neg_y    <= rs_out.neg_y;
      d0_side_ff.reach    <= rs_out.reach;
      d0_side_ff.zero_len <= (sq_root == '0);
      d0_side_ff.ovf_x    <= (RW'(nx_in[PW-1:QW]) >= sq_root);
      d0_side_ff.ovf_y    <= (RW'(ny_in[PW-1:QW]) >= sq_root);
   end

   // dividers, sideband delayed to match
   logic          dvx_v, dvy_v;
   logic [QW-1:0] qx, qy;
   div_side_type  ds_ff [DV_STAGES];

   vmt_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d0_v_ff),
      .in_num    (d0_nx_ff),
      .in_den    (d0_len_ff),
      .out_valid (dvx_v),
      .out_quo   (qx)
   );

   vmt_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d0_v_ff),
      .in_num    (d0_ny_ff),
      .in_den    (d0_len_ff),
      .out_valid (dvy_v),
      .out_quo   (qy)
   );

   always_ff @(posedge clock) begin
      ds_ff[0] <= d0_side_ff;
      for (int i = 1; i < DV_STAGES; i++) begin
         ds_ff[i] <= ds_ff[i-1];
      end
   end

   // cap, sign, add and saturate
   div_side_type  ds_out;
   logic [QW-1:0] cx_q, cy_q;
   logic [OW-1:0] offx, offy, sumx, sumy;

   assign ds_out = ds_ff[DV_STAGES-1];

   always_comb begin
      cx_q = (ds_out.ovf_x || (qx > OFFSET_CAP)) ? OFFSET_CAP : qx;
      cy_q = (ds_out.ovf_y || (qy > OFFSET_CAP)) ? OFFSET_CAP : qy;
      if (ds_out.zero_len) begin
         cx_q = '0;
         cy_q = '0;
      end
      offx = ds_out.neg_x ? OW'(-cx_q) : OW'(cx_q);
      offy = ds_out.neg_y ? OW'(-cy_q) : OW'(cy_q);
      sumx = OW'(signed'(ds_out.cur_x)) + offx;
      sumy = OW'(signed'(ds_out.cur_y)) + offy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dvx_v & dvy_v;
      end
   end

   always_ff @(posedge clock) begin
      rsp_reached <= ds_out.reach;
      rsp_new_x   <= ds_out.reach ? ds_out.tgt_x : sat32(sumx);
      rsp_new_y   <= ds_out.reach ? ds_out.tgt_y : sat32(sumy);
   end

endmodule
